// ----- rtl/usl_pkg.sv -----
// ----------------------------------------------------------------------------
// usl_pkg
// shared constants, types and helpers of the utf-8 lossy sanitiser
// ----------------------------------------------------------------------------
package usl_pkg;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC2;
    localparam logic [7:0] LEAD_MAX    = 8'hF4;
    localparam logic [7:0] LEAD_W3     = 8'hE0;
    localparam logic [7:0] LEAD_W4     = 8'hF0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_LO       = 8'hA0;
    localparam logic [7:0] ED_HI       = 8'h9F;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8F;
    localparam logic [7:0] REP_B0      = 8'hEF;
    localparam logic [7:0] REP_B1      = 8'hBF;
    localparam logic [7:0] REP_B2      = 8'hBD;

    localparam int MAX_PASS = 4;
    localparam int HELD_DEPTH = 3;

    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_BAD,
        LEAD_OPEN
    } lead_class_t;

    typedef enum logic [1:0] {
        REP_IDX0,
        REP_IDX1,
        REP_IDX2
    } rep_idx_t;

    typedef struct packed {
        logic                      rep_a;
        logic [2:0]                pass_cnt;
        logic [MAX_PASS-1:0][7:0]  pass_bytes;
        logic                      rep_c;
        logic                      last;
        logic                      ok;
    } cmd_t;

    function automatic lead_class_t classify_lead(input logic [7:0] b);
        lead_class_t c;
        if (b < ASCII_LIMIT)
        begin
            c = LEAD_ASCII;
        end
        else if (b < LEAD_MIN || b > LEAD_MAX)
        begin
            c = LEAD_BAD;
        end
        else
        begin
            c = LEAD_OPEN;
        end
        return c;
    endfunction

    function automatic logic [2:0] lead_width(input logic [7:0] b);
        logic [2:0] w;
        if (b < LEAD_W3)
        begin
            w = 3'd2;
        end
        else if (b < LEAD_W4)
        begin
            w = 3'd3;
        end
        else
        begin
            w = 3'd4;
        end
        return w;
    endfunction

    function automatic logic [7:0] rep_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            REP_IDX0: r = REP_B0;
            REP_IDX1: r = REP_B1;
            REP_IDX2: r = REP_B2;
            default:  r = REP_B2;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/utf8_lossy_sanitizer_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_lossy_sanitizer_unit
// streaming utf-8 validation with replacement of ill-formed subparts
// ----------------------------------------------------------------------------
// input channel: one raw byte a beat (in_byte, in_last marks the end of a
// span) under in_valid / in_stall. output channel: one sanitised byte a beat
// with run_last, span_end, replaced and span_ok under out_valid / out_stall.
// a beat moves when valid is high and stall is low at a rising edge.
// the classifier takes one input beat a cycle while the queue has room and
// queues a command of one to six output beats; the expander sends one output
// beat a cycle while out_stall is low, so the output port sets the rate once
// the queue is full. a held lead or continuation yields none. an accepted
// input beat's command is registered in the queue, and its first output beat
// then in the output register. in_stall rises when the queue is full; a
// stalled output beat holds in the output register while the queue fills.
// reset clears the open sequence, the error flag, the queue and the output
// stage; the block takes input from the first cycle after reset.
// ----------------------------------------------------------------------------
module utf8_lossy_sanitizer_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       span_end,
    output logic       replaced,
    output logic       span_ok
);

    usl_pkg::cmd_t front_cmd;
    usl_pkg::cmd_t head_cmd;
    logic          has_beats;
    logic          accept;
    logic          q_full;
    logic          head_valid;
    logic          pop;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    usl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd       (front_cmd),
        .has_beats (has_beats)
    );

    usl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && has_beats),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    usl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .span_end   (span_end),
        .replaced   (replaced),
        .span_ok    (span_ok)
    );

endmodule

// ----- rtl/usl_front.sv -----
// ----------------------------------------------------------------------------
// usl_front
// classifies each input beat against the open sequence and issues a command
// ----------------------------------------------------------------------------
module usl_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output usl_pkg::cmd_t cmd,
    output logic          has_beats
);

    logic [usl_pkg::HELD_DEPTH-1:0][7:0] held_reg;
    logic [usl_pkg::HELD_DEPTH-1:0][7:0] held_next;
    logic [1:0]                          cnt_reg;
    logic [1:0]                          cnt_next;
    logic [2:0]                          width_reg;
    logic [2:0]                          width_next;
    logic                                err_reg;
    logic                                err_next;

    logic                  seq_open;
    logic [7:0]            lo;
    logic [7:0]            hi;
    logic                  in_range;
    logic                  complete;
    logic                  redo_lead;
    usl_pkg::lead_class_t  lead_class;

    always_comb
    begin
        cmd        = '0;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        width_next = width_reg;
        err_next   = err_reg;
        redo_lead  = 1'b0;

        seq_open = (width_reg != 3'd0) && (cnt_reg != 2'd0);
        lo = usl_pkg::CONT_LO;
        hi = usl_pkg::CONT_HI;
        if (cnt_reg == 2'd1)
        begin
            case (held_reg[0])
                usl_pkg::LEAD_W3:  lo = usl_pkg::E0_LO;
                usl_pkg::LEAD_ED:  hi = usl_pkg::ED_HI;
                usl_pkg::LEAD_W4:  lo = usl_pkg::F0_LO;
                usl_pkg::LEAD_MAX: hi = usl_pkg::F4_HI;
                default:           lo = usl_pkg::CONT_LO;
            endcase
        end
        in_range   = (in_byte >= lo) && (in_byte <= hi);
        complete   = ({1'b0, cnt_reg} + 3'd1) >= width_reg;
        lead_class = usl_pkg::classify_lead(in_byte);

        if (seq_open)
        begin
            if (in_range)
            begin
                if (complete)
                begin
                    for (int j = 0; j < usl_pkg::HELD_DEPTH; j++)
                    begin
                        if (2'(j) < cnt_reg)
                        begin
                            cmd.pass_bytes[j] = held_reg[j];
                        end
                    end
                    cmd.pass_bytes[cnt_reg] = in_byte;
                    cmd.pass_cnt = {1'b0, cnt_reg} + 3'd1;
                    cnt_next   = 2'd0;
                    width_next = 3'd0;
                end
                else
                begin
                    held_next[cnt_reg] = in_byte;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else
            begin
                cmd.rep_a  = 1'b1;
                cnt_next   = 2'd0;
                width_next = 3'd0;
                redo_lead  = 1'b1;
            end
        end
        else
        begin
            cnt_next   = 2'd0;
            width_next = 3'd0;
            redo_lead  = 1'b1;
        end

        if (redo_lead)
        begin
            case (lead_class)
                usl_pkg::LEAD_ASCII:
                begin
                    cmd.pass_bytes[0] = in_byte;
                    cmd.pass_cnt = 3'd1;
                end
                usl_pkg::LEAD_BAD:
                begin
                    if (seq_open)
                    begin
                        cmd.rep_c = 1'b1;
                    end
                    else
                    begin
                        cmd.rep_a = 1'b1;
                    end
                end
                usl_pkg::LEAD_OPEN:
                begin
                    held_next[0] = in_byte;
                    cnt_next     = 2'd1;
                    width_next   = usl_pkg::lead_width(in_byte);
                end
                default:
                begin
                    cnt_next = 2'd0;
                end
            endcase
        end

        // truncated tail at end of span
        if (in_last)
        begin
            if (width_next != 3'd0)
            begin
                cmd.rep_c  = 1'b1;
                cnt_next   = 2'd0;
                width_next = 3'd0;
            end
            cmd.ok   = !(err_reg || cmd.rep_a || cmd.rep_c);
            err_next = 1'b0;
        end
        else
        begin
            err_next = err_reg || cmd.rep_a || cmd.rep_c;
        end
        cmd.last  = in_last;
        has_beats = cmd.rep_a || cmd.rep_c || (cmd.pass_cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 2'd0;
            width_reg <= 3'd0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg   <= cnt_next;
            width_reg <= width_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- rtl/usl_queue.sv -----
// ----------------------------------------------------------------------------
// usl_queue
// short command queue between the classifier and the expander
// ----------------------------------------------------------------------------
module usl_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  usl_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output usl_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    usl_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/usl_back.sv -----
// ----------------------------------------------------------------------------
// usl_back
// expands one command into output beats through a registered output stage
// ----------------------------------------------------------------------------
module usl_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  usl_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          span_end,
    output logic          replaced,
    output logic          span_ok
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       span_end_reg;
    logic       replaced_reg;
    logic       span_ok_reg;

    logic [2:0] a_len;
    logic [2:0] c_len;
    logic [2:0] total;
    logic [2:0] q;
    logic [2:0] r;
    logic       load;
    logic       beat_last;
    logic [7:0] beat_byte;
    logic       beat_rep;

    always_comb
    begin
        a_len = {1'b0, head_cmd.rep_a, head_cmd.rep_a};
        c_len = {1'b0, head_cmd.rep_c, head_cmd.rep_c};
        total = a_len + head_cmd.pass_cnt + c_len;
        q     = pos_reg - a_len;
        r     = q - head_cmd.pass_cnt;
        if (pos_reg < a_len)
        begin
            beat_byte = usl_pkg::rep_byte(pos_reg[1:0]);
            beat_rep  = 1'b1;
        end
        else if (q < head_cmd.pass_cnt)
        begin
            beat_byte = head_cmd.pass_bytes[q[1:0]];
            beat_rep  = 1'b0;
        end
        else
        begin
            beat_byte = usl_pkg::rep_byte(r[1:0]);
            beat_rep  = 1'b1;
        end
        beat_last = (pos_reg == (total - 3'd1));
        load      = head_valid && (!out_valid_reg || !out_stall);
        pop       = load && beat_last;
        pos_next  = pos_reg;
        if (load)
        begin
            pos_next = beat_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= beat_byte;
            run_last_reg <= beat_last;
            span_end_reg <= beat_last && head_cmd.last;
            replaced_reg <= beat_rep;
            span_ok_reg  <= beat_last && head_cmd.last && head_cmd.ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = run_last_reg;
    assign span_end  = span_end_reg;
    assign replaced  = replaced_reg;
    assign span_ok   = span_ok_reg;

endmodule

// ----- rtl/usl_checker.sv -----
// ----------------------------------------------------------------------------
// usl_checker
// port-level checks of the utf-8 lossy sanitiser output channel
// ----------------------------------------------------------------------------
module usl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       span_end,
    input logic       replaced,
    input logic       span_ok
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(replaced))
        else $error("stalled output beat changed");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_end |-> run_last)
        else $error("span end not on last beat of its run");

    a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_ok |-> span_end)
        else $error("span_ok outside span end");

    a_rep_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && replaced |-> (out_byte == usl_pkg::REP_B0)
            || (out_byte == usl_pkg::REP_B1) || (out_byte == usl_pkg::REP_B2))
        else $error("replacement beat carries a foreign byte");

    a_ok_clean_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_ok |-> !replaced)
        else $error("well-formed span ends on a replacement beat");

endmodule

bind utf8_lossy_sanitizer_unit usl_checker u_usl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .span_end  (span_end),
    .replaced  (replaced),
    .span_ok   (span_ok)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-8 lossy sanitiser
// ----------------------------------------------------------------------------
// a short table of directed beats opens the run: the byte extremes, invalid
// leads, a lone continuation, the narrowed second-byte ranges, a sequence
// broken by a byte that is itself bad, and spans that end inside a sequence.
// random spans follow, mostly well-formed characters with some truncated
// ones and some raw noise bytes. every accepted input beat runs through a
// local model of the sanitiser, and every output beat is compared with the
// oldest expected beat. both sides idle at random in several phases, and
// once the output is held off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED      = 29;
    localparam int N_RANDOM        = 150;
    localparam int PRESSURE_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 100000;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ASCII,
        CHK_REPL
    } chk_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        chk_kind_t  kind;
        logic       ok;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       span_end;
        logic       replaced;
        logic       span_ok;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       span_end;
    logic       replaced;
    logic       span_ok;

    stim_row_t  stim_rows[$];
    logic [7:0] span_bytes[$];
    beat_t      step_beats[$];
    beat_t      expected_beats[$];
    int         stim_idx = 0;
    int         n_rand = 0;
    int         phase_sel = 0;
    int         n_errors = 0;
    int         cycle_cnt = 0;
    int         hold_left = 0;
    bit         pressure_done = 1'b0;
    logic       hold_off = 1'b0;

    int send_idle_pct[5]  = '{0, 0, 50, 0, 30};
    int recv_stall_pct[5] = '{0, 0, 0, 50, 30};

    // sanitiser state
    logic [7:0] seq_bytes[3];
    logic [1:0] seq_held;
    logic [2:0] seq_len;
    logic       span_bad;

    stim_row_t directed_rows[N_DIRECTED] = '{
        '{8'h00, 1'b1, CHK_ASCII, 1'b1},
        '{8'h7F, 1'b0, CHK_ASCII, 1'b0},
        '{8'h80, 1'b0, CHK_REPL,  1'b0},
        '{8'hC1, 1'b1, CHK_REPL,  1'b0},
        '{8'hFF, 1'b1, CHK_REPL,  1'b0},
        '{8'hF5, 1'b0, CHK_REPL,  1'b0},
        '{8'h41, 1'b1, CHK_ASCII, 1'b0},
        '{8'hC2, 1'b0, CHK_NONE,  1'b0},
        '{8'h80, 1'b1, CHK_MODEL, 1'b0},
        '{8'hE0, 1'b0, CHK_NONE,  1'b0},
        '{8'h9F, 1'b0, CHK_MODEL, 1'b0},
        '{8'hE0, 1'b0, CHK_NONE,  1'b0},
        '{8'hA0, 1'b0, CHK_NONE,  1'b0},
        '{8'h80, 1'b1, CHK_MODEL, 1'b0},
        '{8'hED, 1'b0, CHK_NONE,  1'b0},
        '{8'h9F, 1'b0, CHK_NONE,  1'b0},
        '{8'hBF, 1'b0, CHK_MODEL, 1'b0},
        '{8'hED, 1'b0, CHK_NONE,  1'b0},
        '{8'hA0, 1'b1, CHK_MODEL, 1'b0},
        '{8'hF0, 1'b0, CHK_NONE,  1'b0},
        '{8'h90, 1'b0, CHK_NONE,  1'b0},
        '{8'h80, 1'b0, CHK_NONE,  1'b0},
        '{8'hBF, 1'b0, CHK_MODEL, 1'b0},
        '{8'hF4, 1'b0, CHK_NONE,  1'b0},
        '{8'h90, 1'b0, CHK_MODEL, 1'b0},
        '{8'hF4, 1'b0, CHK_NONE,  1'b0},
        '{8'h8F, 1'b0, CHK_NONE,  1'b0},
        '{8'h80, 1'b1, CHK_MODEL, 1'b0},
        '{8'hDF, 1'b1, CHK_MODEL, 1'b0}
    };

    utf8_lossy_sanitizer_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .span_end  (span_end),
        .replaced  (replaced),
        .span_ok   (span_ok)
    );

    always #4 clk = ~clk;

    task automatic emit_beat(input logic [7:0] d, input logic rep);
        beat_t b;
        b = '{data: d, run_last: 1'b0, span_end: 1'b0, replaced: rep, span_ok: 1'b0};
        step_beats.push_back(b);
    endtask

    task automatic emit_fffd();
        emit_beat(usl_pkg::REP_B0, 1'b1);
        emit_beat(usl_pkg::REP_B1, 1'b1);
        emit_beat(usl_pkg::REP_B2, 1'b1);
        span_bad = 1'b1;
    endtask

    task automatic start_char(input logic [7:0] d);
        if (d < usl_pkg::ASCII_LIMIT)
        begin
            emit_beat(d, 1'b0);
        end
        else if (d < usl_pkg::LEAD_MIN || d > usl_pkg::LEAD_MAX)
        begin
            emit_fffd();
        end
        else
        begin
            seq_bytes[0] = d;
            seq_held = 2'd1;
            seq_len = (d < usl_pkg::LEAD_W3) ? 3'd2 : (d < usl_pkg::LEAD_W4) ? 3'd3 : 3'd4;
        end
    endtask

    task automatic sanitise_byte(input logic [7:0] d, input logic last);
        logic [7:0] lo;
        logic [7:0] hi;
        int         k;
        int         n;
        step_beats.delete();
        if (seq_len != 3'd0)
        begin
            k = seq_held;
            lo = usl_pkg::CONT_LO;
            hi = usl_pkg::CONT_HI;
            if (k == 1)
            begin
                if (seq_bytes[0] == usl_pkg::LEAD_W3)
                    lo = usl_pkg::E0_LO;
                else if (seq_bytes[0] == usl_pkg::LEAD_ED)
                    hi = usl_pkg::ED_HI;
                else if (seq_bytes[0] == usl_pkg::LEAD_W4)
                    lo = usl_pkg::F0_LO;
                else if (seq_bytes[0] == usl_pkg::LEAD_MAX)
                    hi = usl_pkg::F4_HI;
            end
            if (d >= lo && d <= hi)
            begin
                if (k + 1 >= int'(seq_len))
                begin
                    for (int j = 0; j < k; j++)
                        emit_beat(seq_bytes[j], 1'b0);
                    emit_beat(d, 1'b0);
                    seq_held = 2'd0;
                    seq_len = 3'd0;
                end
                else
                begin
                    seq_bytes[k] = d;
                    seq_held = 2'(k + 1);
                end
            end
            else
            begin
                emit_fffd();
                seq_held = 2'd0;
                seq_len = 3'd0;
                start_char(d);
            end
        end
        else
        begin
            start_char(d);
        end
        if (last)
        begin
            if (seq_len != 3'd0)
            begin
                emit_fffd();
                seq_held = 2'd0;
                seq_len = 3'd0;
            end
            n = step_beats.size();
            if (n > 0)
            begin
                step_beats[n-1].span_end = 1'b1;
                step_beats[n-1].span_ok = ~span_bad;
            end
            span_bad = 1'b0;
        end
        n = step_beats.size();
        if (n > 0)
            step_beats[n-1].run_last = 1'b1;
    endtask

    function automatic logic [7:0] pick_second(input logic [7:0] lead);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = usl_pkg::CONT_LO;
        hi = usl_pkg::CONT_HI;
        if (lead == usl_pkg::LEAD_W3)
            lo = usl_pkg::E0_LO;
        else if (lead == usl_pkg::LEAD_ED)
            hi = usl_pkg::ED_HI;
        else if (lead == usl_pkg::LEAD_W4)
            lo = usl_pkg::F0_LO;
        else if (lead == usl_pkg::LEAD_MAX)
            hi = usl_pkg::F4_HI;
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic add_char(input bit broken);
        int         w;
        int         keep;
        logic [7:0] cb[4];
        w = $urandom_range(4, 1);
        if (w == 1)
        begin
            span_bytes.push_back(8'($urandom_range(127, 0)));
        end
        else
        begin
            if (w == 2)
                cb[0] = 8'($urandom_range(8'hDF, usl_pkg::LEAD_MIN));
            else if (w == 3)
                cb[0] = 8'($urandom_range(8'hEF, usl_pkg::LEAD_W3));
            else
                cb[0] = 8'($urandom_range(usl_pkg::LEAD_MAX, usl_pkg::LEAD_W4));
            cb[1] = pick_second(cb[0]);
            cb[2] = 8'($urandom_range(usl_pkg::CONT_HI, usl_pkg::CONT_LO));
            cb[3] = 8'($urandom_range(usl_pkg::CONT_HI, usl_pkg::CONT_LO));
            keep = broken ? $urandom_range(w - 1, 1) : w;
            for (int j = 0; j < keep; j++)
                span_bytes.push_back(cb[j]);
        end
    endtask

    function automatic int phase_of(input int idx);
        int q;
        if (idx < N_DIRECTED)
            return 0;
        q = ((idx - N_DIRECTED) * 4) / ((n_rand > 0) ? n_rand : 1);
        return 1 + ((q > 3) ? 3 : q);
    endfunction

    initial
    begin
        int        n_chars;
        int        r;
        stim_row_t row;
        seq_held = 2'd0;
        seq_len = 3'd0;
        span_bad = 1'b0;
        for (int i = 0; i < N_DIRECTED; i++)
            stim_rows.push_back(directed_rows[i]);
        while (stim_rows.size() < N_DIRECTED + N_RANDOM)
        begin
            span_bytes.delete();
            n_chars = $urandom_range(6, 1);
            for (int c = 0; c < n_chars; c++)
            begin
                r = $urandom_range(99, 0);
                if (r < 60)
                    add_char(1'b0);
                else if (r < 80)
                    add_char(1'b1);
                else
                    span_bytes.push_back(8'($urandom_range(255, 0)));
            end
            for (int i = 0; i < span_bytes.size(); i++)
            begin
                row = '{data: span_bytes[i], last: (i == span_bytes.size() - 1),
                        kind: CHK_MODEL, ok: 1'b0};
                stim_rows.push_back(row);
            end
        end
        n_rand = stim_rows.size() - N_DIRECTED;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_idx < stim_rows.size())
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected_beats.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    always @(posedge clk)
    begin : drive_in
        stim_row_t  row;
        beat_t      b;
        int         ph;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                row = stim_rows[stim_idx];
                sanitise_byte(in_byte, in_last);
                case (row.kind)
                    CHK_MODEL:
                    begin
                        foreach (step_beats[j])
                            expected_beats.push_back(step_beats[j]);
                    end
                    CHK_ASCII:
                    begin
                        b = '{data: row.data, run_last: 1'b1, span_end: row.last,
                              replaced: 1'b0, span_ok: row.last & row.ok};
                        expected_beats.push_back(b);
                    end
                    CHK_REPL:
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            b = '{data: (j == 0) ? usl_pkg::REP_B0 :
                                        (j == 1) ? usl_pkg::REP_B1 : usl_pkg::REP_B2,
                                  run_last: (j == 2), span_end: (j == 2) & row.last,
                                  replaced: 1'b1, span_ok: (j == 2) & row.last & row.ok};
                            expected_beats.push_back(b);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                stim_idx++;
            end
            ph = phase_of(stim_idx);
            phase_sel <= ph;
            if (!(in_valid && in_stall))
            begin
                if (stim_idx < stim_rows.size() && $urandom_range(99, 0) >= send_idle_pct[ph])
                begin
                    in_valid <= 1'b1;
                    in_byte <= stim_rows[stim_idx].data;
                    in_last <= stim_rows[stim_idx].last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, once, early in the random part
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!pressure_done && phase_sel == 1)
            begin
                hold_left = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            hold_off <= (hold_left > 0);
            if (hold_left > 0)
                hold_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= hold_off || ($urandom_range(99, 0) < recv_stall_pct[phase_sel]);
    end

    always @(posedge clk)
    begin : check_out
        beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                if (n_errors < 10)
                    $display("unexpected beat: %h rl%0b se%0b rp%0b ok%0b",
                             out_byte, run_last, span_end, replaced, span_ok);
                n_errors++;
            end
            else
            begin
                e = expected_beats.pop_front();
                if (out_byte !== e.data || run_last !== e.run_last ||
                    span_end !== e.span_end || replaced !== e.replaced ||
                    span_ok !== e.span_ok)
                begin
                    if (n_errors < 10)
                    begin
                        $write("beat mismatch: expected %h rl%0b se%0b rp%0b ok%0b",
                               e.data, e.run_last, e.span_end, e.replaced, e.span_ok);
                        $display(", got %h rl%0b se%0b rp%0b ok%0b",
                                 out_byte, run_last, span_end, replaced, span_ok);
                    end
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
